// ----- hw/rtl/vvt_pkg.sv -----
`timescale 1ns / 1ps
package vvt_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int NODE_W = 16;
   localparam int SEQ_W = 32;
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 1;

   typedef enum logic [2:0] {
      OP_INC   = 3'd0,
      OP_GET   = 3'd1,
      OP_SET   = 3'd2,
      OP_MERGE = 3'd3,
      OP_CMP   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      REL_EQUAL      = 2'd0,
      REL_LESS       = 2'd1,
      REL_GREATER    = 2'd2,
      REL_CONCURRENT = 2'd3
   } rel_type;

   typedef enum logic {
      STATUS_OK   = 1'b0,
      STATUS_FULL = 1'b1
   } status_type;

   typedef struct packed {
      logic [NODE_W-1:0] node_id;
      logic [SEQ_W-1:0]  seq;
   } entry_type;

endpackage

// ----- hw/rtl/vvt_store.sv -----
`timescale 1ns / 1ps
module vvt_store #(
   parameter int ENTRIES = vvt_pkg::ENTRIES_DEFAULT,
   parameter int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IW-1:0]       wr_addr,
   input  vvt_pkg::entry_type  wr_data,
   input  logic [IW-1:0]       rd_addr,
   output vvt_pkg::entry_type  rd_data
);
   import vvt_pkg::*;

   entry_type entry_mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/vvt_ctrl.sv -----
`timescale 1ns / 1ps
module vvt_ctrl #(
   parameter int ENTRIES = vvt_pkg::ENTRIES_DEFAULT,
   parameter int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   parameter int CW = $clog2(ENTRIES + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [vvt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [vvt_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                        req_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [vvt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [vvt_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                        wr_en,
   output logic [IW-1:0]               wr_addr,
   output vvt_pkg::entry_type          wr_data,
   output logic [IW-1:0]               rd_addr,
   input  vvt_pkg::entry_type          rd_data
);
   import vvt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [NODE_W-1:0] id_ff, id_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic              has_ff, has_in;
   logic              last_ff, last_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic              rdv_ff, rdv_in;
   logic [IW-1:0]     rdi_ff, rdi_in;
   logic              hit_ff, hit_in;
   logic [IW-1:0]     hidx_ff, hidx_in;
   logic [SEQ_W-1:0]  hseq_ff, hseq_in;
   logic              sweep_ff, sweep_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [ENTRIES-1:0] seen_ff, seen_in;
   logic              lg_ff, lg_in;
   logic              gl_ff, gl_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SEQ_W-1:0]  rsp_value_ff, rsp_value_in;
   rel_type           rsp_rel_ff, rsp_rel_in;
   status_type        rsp_status_ff, rsp_status_in;

   op_type            req_op;
   logic              issue;
   logic              match;
   logic              full_scan;
   logic              tab_full;
   logic              produce;
   logic              stall;
   logic [SEQ_W-1:0]  local_seq;
   logic              lg_next;
   logic              gl_next;

   assign req_op    = op_type'(req_tuser[2:0]);
   assign issue     = scan_ff < count_ff;
   assign match     = rdv_ff && (rd_data.node_id == id_ff);
   assign full_scan = (op_ff == OP_CMP) && last_ff;
   assign tab_full  = count_ff == CW'(ENTRIES);
   assign produce   = (op_ff != OP_CMP) || last_ff;
   assign stall     = produce && rsp_valid_ff && !rsp_tready;
   assign local_seq = hit_ff ? hseq_ff : '0;
   assign lg_next   = lg_ff && !(has_ff && (local_seq < seq_ff));
   assign gl_next   = gl_ff && !(has_ff && (local_seq > seq_ff)) && !sweep_ff;

   assign req_tready = state_ff == ST_IDLE;
   assign rd_addr    = scan_ff[IW-1:0];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      seq_in        = seq_ff;
      has_in        = has_ff;
      last_in       = last_ff;
      scan_in       = scan_ff;
      rdv_in        = rdv_ff;
      rdi_in        = rdi_ff;
      hit_in        = hit_ff;
      hidx_in       = hidx_ff;
      hseq_in       = hseq_ff;
      sweep_in      = sweep_ff;
      count_in      = count_ff;
      seen_in       = seen_ff;
      lg_in         = lg_ff;
      gl_in         = gl_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_rel_in    = rsp_rel_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = hidx_ff;
      wr_data       = '{node_id: id_ff, seq: seq_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_op;
               id_in    = req_tdata[15:0];
               seq_in   = req_tdata[47:16];
               has_in   = req_tuser[3];
               last_in  = req_tlast;
               scan_in  = '0;
               rdv_in   = 1'b0;
               hit_in   = 1'b0;
               sweep_in = 1'b0;
               if (req_op <= OP_CMP) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rdv_in = issue;
            rdi_in = scan_ff[IW-1:0];
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (match && !hit_ff) begin
               hit_in  = 1'b1;
               hidx_in = rdi_ff;
               hseq_in = rd_data.seq;
            end
            // unseen nonzero local entries at the end of a compare run
            if (full_scan && rdv_ff && !seen_ff[rdi_ff] && (rd_data.seq != '0)
                && !(match && has_ff)) begin
               sweep_in = 1'b1;
            end
            if ((!rdv_ff && !issue) || (!full_scan && (hit_ff || match))) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (!stall) begin
               state_in = ST_IDLE;
               if (produce) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_rel_in    = REL_EQUAL;
                  rsp_status_in = STATUS_OK;
               end
               case (op_ff)
                  OP_INC: begin
                     if (hit_ff) begin
                        wr_en        = 1'b1;
                        wr_data.seq  = hseq_ff + 1'b1;
                        rsp_value_in = hseq_ff + 1'b1;
                     end else if (!tab_full) begin
                        wr_en        = 1'b1;
                        wr_addr      = count_ff[IW-1:0];
                        wr_data.seq  = SEQ_W'(1);
                        rsp_value_in = SEQ_W'(1);
                        count_in     = count_ff + 1'b1;
                     end else begin
                        rsp_status_in = STATUS_FULL;
                     end
                  end
                  OP_GET: begin
                     rsp_value_in = local_seq;
                  end
                  OP_SET, OP_MERGE: begin
                     if (hit_ff) begin
                        wr_en = (op_ff == OP_SET) || (seq_ff > hseq_ff);
                     end else if (!tab_full) begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IW-1:0];
                        count_in = count_ff + 1'b1;
                     end else begin
                        rsp_status_in = STATUS_FULL;
                     end
                  end
                  OP_CMP: begin
                     lg_in = lg_next;
                     gl_in = gl_next;
                     if (has_ff && hit_ff) begin
                        seen_in[hidx_ff] = 1'b1;
                     end
                     if (last_ff) begin
                        if (lg_next && gl_next) begin
                           rsp_rel_in = REL_EQUAL;
                        end else if (gl_next) begin
                           rsp_rel_in = REL_LESS;
                        end else if (lg_next) begin
                           rsp_rel_in = REL_GREATER;
                        end else begin
                           rsp_rel_in = REL_CONCURRENT;
                        end
                        seen_in = '0;
                        lg_in   = 1'b1;
                        gl_in   = 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      seq_ff        <= seq_in;
      has_ff        <= has_in;
      last_ff       <= last_in;
      scan_ff       <= scan_in;
      rdi_ff        <= rdi_in;
      hidx_ff       <= hidx_in;
      hseq_ff       <= hseq_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_rel_ff    <= rsp_rel_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rdv_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         sweep_ff     <= 1'b0;
         count_ff     <= '0;
         seen_ff      <= '0;
         lg_ff        <= 1'b1;
         gl_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rdv_ff       <= rdv_in;
         hit_ff       <= hit_in;
         sweep_ff     <= sweep_in;
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         lg_ff        <= lg_in;
         gl_ff        <= gl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_rel_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("entry count beyond table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (count_ff == $past(count_ff) + 1'b1))
      else $error("entry count moved by more than one");

   a_write_apply: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_APPLY) && !stall)
      else $error("table write outside apply step");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_APPLY))
      else $error("result raised without an apply step");

endmodule

// ----- hw/rtl/version_vector_table_core.sv -----
`timescale 1ns / 1ps
// Version vector table of up to ENTRIES (node id, sequence) pairs held in one
// synchronous memory; an absent node reads as 0. Each request transfer is
// looked up by scanning the stored entries in order, one memory read a cycle,
// then applied in a single read-modify-write step. A miss or a compare marked
// last scans all entry_count entries, while a lookup stops at its hit. The
// next request is taken in the cycle after the result step. A compare
// marked last always scans the whole table to find unseen nonzero entries.
// Requests are taken one at a time; a finished result sits in an output
// register so the next request can be accepted while it waits, but that
// request's result step holds until the earlier result is taken.
// Increment, set and merge on a miss into a full table are dropped with
// status 1. Codes 5 to 7 in req_type are consumed without a result.
module version_vector_table_core #(
   parameter int ENTRIES = vvt_pkg::ENTRIES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [vvt_pkg::REQ_DATA_W-1:0] req_tdata,  // node_id, seq
   input  logic [vvt_pkg::REQ_USER_W-1:0] req_tuser,  // req_type, has_entry
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [vvt_pkg::RSP_DATA_W-1:0] rsp_tdata,  // value, relation, zero fill
   output logic [vvt_pkg::RSP_USER_W-1:0] rsp_tuser   // status
);
   import vvt_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;
   logic [IW-1:0] rd_addr;
   entry_type     rd_data;

   vvt_ctrl #(
      .ENTRIES(ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   vvt_store #(
      .ENTRIES(ENTRIES)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

endmodule
